>>> src/pint_pkg.sv
// pint_pkg: shared types and constants of the pose interpolator
// used by pint_div, pint_lane and pose_interpolator_unit; no dependencies
package pint_pkg;

    // run length limit and index width
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;

    // fixed-point angle constants, Q16 radians
    localparam int PI_Q16     = 205887;
    localparam int TWO_PI_Q16 = 2 * PI_Q16;
    // pi plus enough whole turns to keep the wrap value positive
    localparam int WRAP_BIAS  = PI_Q16 + 21 * TWO_PI_Q16;
    // wrap tries 32, 16, 8, 4, 2 and 1 whole turns, one per cycle
    localparam int WRAP_SH_MAX = 5;

    // per-point divisor and remainder width
    localparam int MOD_W = 6;

    // shared divider sizes, two quotient bits per cycle; divisor is N-1
    localparam int DVD_W     = 32;
    localparam int DVS_W     = MOD_W;
    localparam int DIV_STEPS = DVD_W / 2;

    // number of interpolated channels: x, y, z, heading
    localparam int NUM_LANES = 4;
    localparam int LANE_HDG  = 3;

    // sequencer controls toward one interpolation lane
    typedef struct packed {
        logic set_base;
        logic set_step;
        logic advance;
    } t_lane_ctl;

endpackage

>>> src/pint_div.sv
// pint_div: shared unsigned restoring divider, two quotient bits per cycle
// depends on pint_pkg for operand widths and step count
module pint_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pint_pkg::DVD_W-1:0]  i_dividend,
    input  logic [pint_pkg::DVS_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [pint_pkg::DVD_W-1:0]  o_quotient,
    output logic [pint_pkg::DVS_W-1:0]  o_remainder
);

    logic                        r_busy;
    logic                        r_done;
    logic [3:0]                  r_cnt;
    logic [pint_pkg::DVD_W-1:0]  r_quo;
    logic [pint_pkg::DVS_W:0]    r_rem;
    logic [pint_pkg::DVS_W-1:0]  r_dvs;
    logic [pint_pkg::DVD_W-1:0]  n_quo;
    logic [pint_pkg::DVS_W:0]    n_rem;

    // two shift-compare-subtract steps per cycle
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            n_rem = {n_rem[pint_pkg::DVS_W-1:0], n_quo[pint_pkg::DVD_W-1]};
            n_quo = {n_quo[pint_pkg::DVD_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_dvs}) begin
                n_rem    = n_rem - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(pint_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[pint_pkg::DVS_W-1:0];

endmodule

>>> src/pint_lane.sv
// pint_lane: one interpolation channel, adds quotient and remainder per point
// depends on pint_pkg for the control struct and widths
module pint_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pint_pkg::t_lane_ctl         i_ctl,
    input  logic signed [31:0]          i_base,
    input  logic                        i_neg,
    input  logic [31:0]                 i_quo,
    input  logic [pint_pkg::MOD_W-1:0]  i_rem,
    input  logic [pint_pkg::MOD_W-1:0]  i_div,
    output logic signed [31:0]          o_value
);

    logic signed [31:0]          r_base;
    logic                        r_neg;
    logic [31:0]                 r_quo;
    logic [pint_pkg::MOD_W-1:0]  r_rem;
    logic [31:0]                 r_acc_q;
    logic [pint_pkg::MOD_W-1:0]  r_acc_r;
    logic [pint_pkg::MOD_W:0]    w_sum_r;
    logic                        w_carry;

    // remainder accumulation: carry into the quotient on reaching the divisor
    assign w_sum_r = {1'b0, r_acc_r} + {1'b0, r_rem};
    assign w_carry = (w_sum_r >= {1'b0, i_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_q <= '0;
            r_acc_r <= '0;
        end else if (i_ctl.set_base) begin
            r_acc_q <= '0;
            r_acc_r <= '0;
        end else if (i_ctl.advance) begin
            if (w_carry) begin
                r_acc_q <= r_acc_q + r_quo + 32'd1;
                r_acc_r <= pint_pkg::MOD_W'(w_sum_r - {1'b0, i_div});
            end else begin
                r_acc_q <= r_acc_q + r_quo;
                r_acc_r <= w_sum_r[pint_pkg::MOD_W-1:0];
            end
        end
    end

    // start value and per-point step
    always_ff @(posedge i_clk) begin
        if (i_ctl.set_base) begin
            r_base <= i_base;
        end
        if (i_ctl.set_step) begin
            r_neg <= i_neg;
            r_quo <= i_quo;
            r_rem <= i_rem;
        end
    end

    // signed offset from the start value, truncated toward zero
    assign o_value = r_base + (r_neg ? -$signed(r_acc_q) : $signed(r_acc_q));

endmodule

>>> src/pose_interpolator_unit.sv
// pose_interpolator_unit: top level, sequencer around the shared divider
// depends on pint_pkg, pint_div and pint_lane
//
// Takes one request word (start pose, end pose, step count N) and returns N
// pose words from start to end, both included, the last one with tlast set.
// N of 0 or 1 returns start then end unchanged; N above 64 is taken as 64.
// Headings move along the shortest turn, wrapped into (-pi, pi]. A request
// is accepted, the heading difference is wrapped by compare and subtract of
// whole turns (skipped for N below 2), the four differences are divided by
// N-1 on the one shared radix-4 divider, and the words then leave at one
// word per cycle while the output is taken. The request side is ready only
// while no request is in work; the last result word may still wait in the
// output register when the next request is accepted.
module pose_interpolator_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // fields from bit 0: start_x, start_y, start_z, start_heading,
    // end_x, end_y, end_z, end_heading, step_count, zero pad
    input  logic [247:0]  i_s_tdata,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // fields from bit 0: pose_x, pose_y, pose_z, pose_heading, point_index,
    // zero pad
    output logic [127:0]  o_m_tdata,
    // last_point
    output logic          o_m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRAP,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    t_state                          r_state;
    logic [1:0]                      r_ch;
    logic [pint_pkg::IDX_W-1:0]      r_idx;
    logic [pint_pkg::MOD_W-1:0]      r_m;
    logic signed [32:0]              r_d [pint_pkg::NUM_LANES];
    logic [25:0]                     r_wrap;
    logic [2:0]                      r_wrap_sh;
    logic                            r_m_tvalid;
    logic [127:0]                    r_m_tdata;
    logic                            r_m_tlast;

    logic                            w_in_acc;
    logic                            w_load;
    logic [pint_pkg::CNT_W-1:0]      w_n;
    logic                            w_short;
    logic [pint_pkg::MOD_W-1:0]      w_m;
    logic signed [31:0]              w_sx, w_sy, w_sz, w_ex, w_ey, w_ez;
    logic signed [22:0]              w_sh, w_eh;
    logic signed [23:0]              w_dh_raw;
    logic [25:0]                     w_wrap_num;
    logic [25:0]                     w_wrap_turns;
    logic [25:0]                     w_wrap_next;
    logic signed [20:0]              w_dh_wrap;
    logic signed [32:0]              w_d_sel;
    logic [32:0]                     w_mag;
    logic                            w_div_start;
    logic [pint_pkg::DVD_W-1:0]      w_dividend;
    logic [pint_pkg::DVS_W-1:0]      w_divisor;
    logic                            w_div_done;
    logic [pint_pkg::DVD_W-1:0]      w_div_quo;
    logic [pint_pkg::DVS_W-1:0]      w_div_rem;
    pint_pkg::t_lane_ctl             w_ctl [pint_pkg::NUM_LANES];
    logic signed [31:0]              w_base [pint_pkg::NUM_LANES];
    logic signed [31:0]              w_val [pint_pkg::NUM_LANES];

    // request word fields
    assign w_sx = i_s_tdata[31:0];
    assign w_sy = i_s_tdata[63:32];
    assign w_sz = i_s_tdata[95:64];
    assign w_sh = i_s_tdata[118:96];
    assign w_ex = i_s_tdata[150:119];
    assign w_ey = i_s_tdata[182:151];
    assign w_ez = i_s_tdata[214:183];
    assign w_eh = i_s_tdata[237:215];
    assign w_n  = i_s_tdata[244:238];

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);

    // step divisor: N-1 after saturation, 1 for a short run
    assign w_short = (w_n < pint_pkg::CNT_W'(2));
    always_comb begin
        if (w_short) begin
            w_m = pint_pkg::MOD_W'(1);
        end else if (w_n > pint_pkg::CNT_W'(pint_pkg::MAX_POINTS)) begin
            w_m = pint_pkg::MOD_W'(pint_pkg::MAX_POINTS - 1);
        end else begin
            w_m = pint_pkg::MOD_W'(w_n - pint_pkg::CNT_W'(1));
        end
    end

    assign w_dh_raw = {w_eh[22], w_eh} - {w_sh[22], w_sh};

    // heading wrap: pi - ((pi - d) mod 2pi), one whole-turn multiple per cycle
    assign w_wrap_num   = 26'(pint_pkg::WRAP_BIAS) - {{2{w_dh_raw[23]}}, w_dh_raw};
    assign w_wrap_turns = 26'(pint_pkg::TWO_PI_Q16) << r_wrap_sh;
    assign w_wrap_next  = (r_wrap >= w_wrap_turns) ? (r_wrap - w_wrap_turns) : r_wrap;
    assign w_dh_wrap    = 21'(pint_pkg::PI_Q16) - 21'(w_wrap_next);

    // magnitude of the selected difference
    assign w_d_sel = r_d[r_ch];
    assign w_mag   = w_d_sel[32] ? 33'(-w_d_sel) : 33'(w_d_sel);

    assign w_div_start = (r_state == S_DIV_GO);
    assign w_dividend  = w_mag[31:0];
    assign w_divisor   = r_m;

    pint_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    // lane start values and controls
    assign w_base[0] = w_sx;
    assign w_base[1] = w_sy;
    assign w_base[2] = w_sz;
    assign w_base[3] = {{9{w_sh[22]}}, w_sh};

    assign w_load = (r_state == S_EMIT) && (!r_m_tvalid || i_m_tready);

    for (genvar g = 0; g < pint_pkg::NUM_LANES; g++) begin : g_lane
        assign w_ctl[g].set_base = w_in_acc;
        assign w_ctl[g].set_step = (r_state == S_DIV_WAIT) && w_div_done
                                 && (r_ch == 2'(g));
        assign w_ctl[g].advance  = w_load;

        pint_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_base  (w_base[g]),
            .i_neg   (w_d_sel[32]),
            .i_quo   (w_div_quo),
            .i_rem   (w_div_rem),
            .i_div   (r_m),
            .o_value (w_val[g])
        );
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ch       <= '0;
            r_idx      <= '0;
            r_wrap_sh  <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_ch      <= '0;
                        r_idx     <= '0;
                        r_wrap_sh <= 3'(pint_pkg::WRAP_SH_MAX);
                        r_state   <= w_short ? S_DIV_GO : S_WRAP;
                    end
                end
                S_WRAP: begin
                    r_wrap_sh <= r_wrap_sh - 3'd1;
                    if (r_wrap_sh == '0) begin
                        r_state <= S_DIV_GO;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_ch    <= r_ch + 2'd1;
                        r_state <= (r_ch == 2'(pint_pkg::NUM_LANES - 1)) ? S_EMIT : S_DIV_GO;
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_idx <= r_idx + pint_pkg::IDX_W'(1);
                        if (r_idx == r_m) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // request payload: step divisor, differences and heading wrap value
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_m    <= w_m;
            r_d[0] <= {w_ex[31], w_ex} - {w_sx[31], w_sx};
            r_d[1] <= {w_ey[31], w_ey} - {w_sy[31], w_sy};
            r_d[2] <= {w_ez[31], w_ez} - {w_sz[31], w_sz};
            r_d[3] <= {{9{w_dh_raw[23]}}, w_dh_raw};
            r_wrap <= w_wrap_num;
        end else if (r_state == S_WRAP) begin
            r_wrap <= w_wrap_next;
            if (r_wrap_sh == '0) begin
                r_d[3] <= {{12{w_dh_wrap[20]}}, w_dh_wrap};
            end
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_tdata <= {2'b00, r_idx, w_val[3][23:0], w_val[2], w_val[1], w_val[0]};
            r_m_tlast <= (r_idx == r_m);
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tlast  = r_m_tlast;

    // divider finishes only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider result outside a wait state");

    // an accepted request starts the wrap or a division
    a_acc_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_WRAP || r_state == S_DIV_GO))
        else $error("request accepted but sequencer stayed idle");

    // loading the last point ends the run and flags it
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_idx == r_m) |=> (r_state == S_IDLE && o_m_tvalid && o_m_tlast))
        else $error("last point did not close the run");

    // no word is loaded over one that waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !w_load)
        else $error("result word overwritten while waiting");

endmodule
